### sv/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMP(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
		else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
		else $error("assertion failed: next-cycle implication");

`endif

### sv/urb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package urb_pkg;

	// Ring sizes; one slot of each ring always stays empty.
	localparam int RX_DEPTH = 8;
	localparam int TX_DEPTH = 32;
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int TX_AW    = $clog2(TX_DEPTH);

	typedef enum logic [1:0] {
		OP_RX_BYTE  = 2'd0,
		OP_GET      = 2'd1,
		OP_PUT      = 2'd2,
		OP_TX_READY = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RX_DROP   = 2'd1,
		ST_PUT_RETRY = 2'd2,
		ST_PUT_DROP  = 2'd3
	} status_t;

	// Memory access for the receive ring.
	typedef struct packed {
		logic             we;
		logic [RX_AW-1:0] waddr;
		logic             re;
		logic [RX_AW-1:0] raddr;
	} rx_port_t;

	// Memory access for the transmit ring.
	typedef struct packed {
		logic             we;
		logic [TX_AW-1:0] waddr;
		logic             re;
		logic [TX_AW-1:0] raddr;
	} tx_port_t;

	// Registered result flags; byte payloads come from the memories.
	typedef struct packed {
		logic    valid;
		logic    rx_hit;
		logic    tx_hit;
		logic    has_char;
		logic    irq;
		status_t status;
	} res_t;

endpackage

`default_nettype wire

### sv/urb_ram.sv
`timescale 1ns / 1ps
`default_nettype none

// Simple dual-port RAM, one write and one registered read per cycle.
module urb_ram #(
	parameter int DEPTH = 8,
	parameter int WIDTH = 8,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// read port, data registered in the cycle after the address
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

### sv/urb_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

// Ring pointers, interrupt enable, mode register and the result register.
module urb_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire logic [1:0]          opcode,
	input  wire logic                cfg_we,
	input  wire logic                cfg_wdata,
	output urb_pkg::rx_port_t        rx_port,
	output urb_pkg::tx_port_t        tx_port,
	output urb_pkg::res_t            res_s1
);

	localparam int RX_AW = urb_pkg::RX_AW;
	localparam int TX_AW = urb_pkg::TX_AW;

	logic [RX_AW-1:0] rx_head_q, rx_tail_q, rx_head_d, rx_tail_d, rx_head_nx, rx_tail_nx;
	logic [TX_AW-1:0] tx_head_q, tx_tail_q, tx_head_d, tx_tail_d, tx_head_nx, tx_tail_nx;
	logic             irq_q, irq_d;
	logic             drop_q;
	logic             rx_full, rx_empty, tx_full, tx_empty;
	urb_pkg::res_t    res_d;

	function automatic logic [RX_AW-1:0] rx_adv(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(urb_pkg::RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
	endfunction

	function automatic logic [TX_AW-1:0] tx_adv(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(urb_pkg::TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
	endfunction

	// ring occupancy
	assign rx_head_nx = rx_adv(rx_head_q);
	assign rx_tail_nx = rx_adv(rx_tail_q);
	assign tx_head_nx = tx_adv(tx_head_q);
	assign tx_tail_nx = tx_adv(tx_tail_q);
	assign rx_full    = (rx_head_nx == rx_tail_q);
	assign rx_empty   = (rx_head_q == rx_tail_q);
	assign tx_full    = (tx_head_nx == tx_tail_q);
	assign tx_empty   = (tx_head_q == tx_tail_q);

	// operation decode, memory commands and next pointers
	always_comb begin
		rx_head_d     = rx_head_q;
		rx_tail_d     = rx_tail_q;
		tx_head_d     = tx_head_q;
		tx_tail_d     = tx_tail_q;
		irq_d         = irq_q;
		rx_port.we    = 1'b0;
		rx_port.waddr = rx_head_q;
		rx_port.re    = 1'b0;
		rx_port.raddr = rx_tail_q;
		tx_port.we    = 1'b0;
		tx_port.waddr = tx_head_q;
		tx_port.re    = 1'b0;
		tx_port.raddr = tx_tail_q;
		res_d         = '0;
		res_d.status  = urb_pkg::ST_OK;
		if (accept) begin
			res_d.valid = 1'b1;
			case (urb_pkg::op_t'(opcode))
				urb_pkg::OP_RX_BYTE: begin
					if (!rx_full) begin
						rx_port.we = 1'b1;
						rx_head_d  = rx_head_nx;
					end else begin
						res_d.status = urb_pkg::ST_RX_DROP;
					end
				end
				urb_pkg::OP_GET: begin
					if (!rx_empty) begin
						rx_port.re   = 1'b1;
						rx_tail_d    = rx_tail_nx;
						res_d.rx_hit = 1'b1;
					end
				end
				urb_pkg::OP_PUT: begin
					if (!tx_full) begin
						tx_port.we = 1'b1;
						tx_head_d  = tx_head_nx;
						irq_d      = 1'b1;
					end else if (drop_q) begin
						res_d.status = urb_pkg::ST_PUT_DROP;
					end else begin
						res_d.status = urb_pkg::ST_PUT_RETRY;
					end
				end
				urb_pkg::OP_TX_READY: begin
					if (!tx_empty) begin
						tx_port.re   = 1'b1;
						tx_tail_d    = tx_tail_nx;
						res_d.tx_hit = 1'b1;
					end
					if (tx_head_q == tx_tail_d) begin
						irq_d = 1'b0;
					end
				end
				default: begin
				end
			endcase
		end
		res_d.has_char = (rx_head_d != rx_tail_d);
		res_d.irq      = irq_d;
	end

	// pointer and flag registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_head_q <= '0;
			rx_tail_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			irq_q     <= 1'b0;
			drop_q    <= 1'b0;
		end else begin
			rx_head_q <= rx_head_d;
			rx_tail_q <= rx_tail_d;
			tx_head_q <= tx_head_d;
			tx_tail_q <= tx_tail_d;
			irq_q     <= irq_d;
			if (cfg_we) begin
				drop_q <= cfg_wdata;
			end
		end
	end

	// result register, lines up with the memory read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_s1 <= '0;
		end else begin
			res_s1 <= res_d;
		end
	end

	`ASSERT_NEXT(a_beat_follows_accept, clk, arst_n, accept, res_s1.valid)
	`ASSERT_NEXT(a_put_sets_irq, clk, arst_n,
		accept && opcode == urb_pkg::OP_PUT && !tx_full, irq_q && res_s1.irq)
	`ASSERT_IMP(a_drop_no_data, clk, arst_n, res_s1.status != urb_pkg::ST_OK,
		!res_s1.rx_hit && !res_s1.tx_hit)
	`ASSERT_IMP(a_irq_tracks_ring, clk, arst_n, tx_empty && !irq_q,
		tx_head_q == tx_tail_q)

endmodule

`default_nettype wire

### sv/uart_rx_tx_ring_buffers.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                        Handshake
// command   opcode, data_byte                              start & !busy
// result    read_byte, has_char, line_valid, line_byte,    done, one cycle
//           tx_irq_enable, status
// config    cfg_wdata (tx_drop_on_full)                    cfg_we
//
// One command per cycle; its result beat is on the outputs in the next cycle.
// The ring entry for a get or a transmitter-ready pop is read from the ring
// RAM at the accepting edge; its registered read port sets the delay.
// busy never rises: every command finishes in that cycle.
// arst_n clears the pointers, the interrupt enable and the mode register.
// Ring contents are not cleared; only written entries are ever read.
module uart_rx_tx_ring_buffers (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       start,
	output logic            busy,
	input  wire logic [1:0] opcode,
	input  wire logic [7:0] data_byte,
	input  wire logic       cfg_we,
	input  wire logic       cfg_wdata,
	output logic            done,
	output logic [7:0]      read_byte,
	output logic            has_char,
	output logic            line_valid,
	output logic [7:0]      line_byte,
	output logic            tx_irq_enable,
	output logic [1:0]      status
);

	urb_pkg::rx_port_t rx_port;
	urb_pkg::tx_port_t tx_port;
	urb_pkg::res_t     res_s1;
	logic [7:0]        rx_rdata;
	logic [7:0]        tx_rdata;
	logic              accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	urb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.opcode    (opcode),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.rx_port   (rx_port),
		.tx_port   (tx_port),
		.res_s1    (res_s1)
	);

	// receive ring storage
	urb_ram #(
		.DEPTH (urb_pkg::RX_DEPTH),
		.WIDTH (8)
	) u_rx_ram (
		.clk   (clk),
		.we    (rx_port.we),
		.waddr (rx_port.waddr),
		.wdata (data_byte),
		.re    (rx_port.re),
		.raddr (rx_port.raddr),
		.rdata (rx_rdata)
	);

	// transmit ring storage
	urb_ram #(
		.DEPTH (urb_pkg::TX_DEPTH),
		.WIDTH (8)
	) u_tx_ram (
		.clk   (clk),
		.we    (tx_port.we),
		.waddr (tx_port.waddr),
		.wdata (data_byte),
		.re    (tx_port.re),
		.raddr (tx_port.raddr),
		.rdata (tx_rdata)
	);

	// result beat
	assign done          = res_s1.valid;
	assign read_byte     = res_s1.rx_hit ? rx_rdata : 8'd0;
	assign has_char      = res_s1.has_char;
	assign line_valid    = res_s1.tx_hit;
	assign line_byte     = res_s1.tx_hit ? tx_rdata : 8'd0;
	assign tx_irq_enable = res_s1.irq;
	assign status        = res_s1.status;

endmodule

`default_nettype wire
